// ===== design/plrbd_pkg.sv =====
// ----------------------------------------------------------------------------
// plrbd_pkg
// Shared types and constants for the phone line ring and battery detector.
// ----------------------------------------------------------------------------
package plrbd_pkg;

  localparam int FreqW    = 8;
  localparam int MsW      = 14;
  localparam int ProdW    = FreqW + MsW;
  localparam int RingCntW = 16;
  localparam int RingLeftW = 15;
  localparam int BatCntW  = 8;
  localparam int CfgIdxW  = 3;
  localparam int LimW     = 28;

  localparam logic [FreqW-1:0] FreqReset   = 8'd25;
  localparam logic [MsW-1:0]   OnReset     = 14'd1000;
  localparam logic [MsW-1:0]   OffReset    = 14'd4000;
  localparam logic [MsW-1:0]   BatReset    = 14'd100;
  localparam logic [MsW-1:0]   CidReset    = 14'd100;
  localparam logic [ProdW-1:0] ProdReset   = 22'd25000;
  localparam logic [LimW-1:0]  ThreshDiv   = 28'd2000;
  localparam logic [RingCntW-1:0] ThreshMin = 16'd3;
  localparam logic [MsW:0]     CidExtra    = 15'd10;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_RING     = 2'd1,
    OP_BATTERY  = 2'd2,
    OP_POLARITY = 2'd3
  } op_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RING_FREQ  = 3'd0,
    REG_RING_ON    = 3'd1,
    REG_RING_OFF   = 3'd2,
    REG_BAT_WINDOW = 3'd3,
    REG_CID_WINDOW = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    RK_IDLE = 2'd0,
    RK_ON   = 2'd1,
    RK_END  = 2'd2
  } ring_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_CID  = 2'd1,
    BK_BAT  = 2'd2
  } bat_kind_t;

  typedef struct packed {
    logic [ProdW-1:0] freq_on_prod;
    logic [MsW-1:0]   ring_on_ms;
    logic [MsW-1:0]   ring_off_ms;
    logic [MsW-1:0]   bat_window_ms;
    logic [MsW-1:0]   cid_window_ms;
  } cfg_t;

  typedef struct packed {
    logic ring_on;
    logic ring_off;
    logic battery;
    logic polarity;
  } events_t;

endpackage

// ===== design/plrbd_cfg.sv =====
// ----------------------------------------------------------------------------
// plrbd_cfg
// Configuration registers, with the frequency times on-window product kept
// up to date at write time.
// ----------------------------------------------------------------------------
module plrbd_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [plrbd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [plrbd_pkg::MsW-1:0]     cfg_data,
  output plrbd_pkg::cfg_t               cfg
);
  import plrbd_pkg::*;

  logic [FreqW-1:0] ring_freq_hz;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_freq_hz      <= FreqReset;
      cfg.freq_on_prod  <= ProdReset;
      cfg.ring_on_ms    <= OnReset;
      cfg.ring_off_ms   <= OffReset;
      cfg.bat_window_ms <= BatReset;
      cfg.cid_window_ms <= CidReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RING_FREQ: begin
          ring_freq_hz     <= cfg_data[FreqW-1:0];
          cfg.freq_on_prod <= ProdW'(cfg_data[FreqW-1:0]) * ProdW'(cfg.ring_on_ms);
        end
        REG_RING_ON: begin
          cfg.ring_on_ms   <= cfg_data;
          cfg.freq_on_prod <= ProdW'(ring_freq_hz) * ProdW'(cfg_data);
        end
        REG_RING_OFF:   cfg.ring_off_ms   <= cfg_data;
        REG_BAT_WINDOW: cfg.bat_window_ms <= cfg_data;
        REG_CID_WINDOW: cfg.cid_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/plrbd_engine.sv =====
// ----------------------------------------------------------------------------
// plrbd_engine
// Ring and battery window state. Updates the state for one word and gives
// the events that the word causes.
// ----------------------------------------------------------------------------
module plrbd_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [1:0]           op,
  input  logic                 on_hook,
  input  plrbd_pkg::cfg_t      cfg,
  output plrbd_pkg::events_t   events
);
  import plrbd_pkg::*;

  logic [RingCntW-1:0]  ring_pulse_count, ring_pulse_count_next;
  logic                 ringing_active, ringing_active_next;
  logic [RingLeftW-1:0] ring_timer_left, ring_timer_left_next;
  ring_kind_t           ring_timer_kind, ring_timer_kind_next;
  logic [BatCntW-1:0]   bat_pulse_count, bat_pulse_count_next;
  logic [MsW-1:0]       bat_timer_left, bat_timer_left_next;
  bat_kind_t            bat_timer_kind, bat_timer_kind_next;
  logic                 cid_done, cid_done_next;
  logic                 cid_pending, cid_pending_next;

  logic [LimW-1:0] limit;
  logic            above_thresh;
  logic            ring_expire;
  logic            bat_expire;
  logic [MsW:0]    cid_len;

  // The count reaches max(3, prod / 2000) exactly when it is at least three and
  // (count + 1) * 2000 exceeds the product.
  assign limit        = (LimW'(ring_pulse_count) + LimW'(1)) * ThreshDiv;
  assign above_thresh = (ring_pulse_count >= ThreshMin) &&
                        (limit > LimW'(cfg.freq_on_prod));
  assign ring_expire  = (ring_timer_kind != RK_IDLE) && (ring_timer_left <= RingLeftW'(1));
  assign bat_expire   = (bat_timer_kind != BK_IDLE) && (bat_timer_left <= MsW'(1));
  assign cid_len      = {1'b0, cfg.cid_window_ms} + CidExtra;

  always_comb begin
    ring_pulse_count_next = ring_pulse_count;
    ringing_active_next   = ringing_active;
    ring_timer_left_next  = ring_timer_left;
    ring_timer_kind_next  = ring_timer_kind;
    bat_pulse_count_next  = bat_pulse_count;
    bat_timer_left_next   = bat_timer_left;
    bat_timer_kind_next   = bat_timer_kind;
    cid_done_next         = cid_done;
    cid_pending_next      = cid_pending;
    events                = '0;

    case (op_t'(op))
      OP_TICK: begin
        if (ring_timer_kind != RK_IDLE) begin
          ring_timer_left_next = ring_expire ? '0 : ring_timer_left - RingLeftW'(1);
        end
        if (ring_expire) begin
          ring_timer_kind_next = RK_IDLE;
          if (ring_timer_kind == RK_ON) begin
            if (above_thresh) begin
              events.ring_on      = 1'b1;
              ringing_active_next = 1'b1;
            end
            ring_pulse_count_next = '0;
          end else if (!above_thresh) begin
            events.ring_off       = 1'b1;
            ring_pulse_count_next = '0;
            ringing_active_next   = 1'b0;
          end
        end
        if (bat_timer_kind != BK_IDLE) begin
          bat_timer_left_next = bat_expire ? '0 : bat_timer_left - MsW'(1);
        end
        if (bat_expire) begin
          bat_timer_kind_next = BK_IDLE;
          if (bat_timer_kind == BK_CID) begin
            cid_done_next    = 1'b1;
            cid_pending_next = 1'b0;
          end else begin
            if (!ringing_active_next) begin
              if (bat_pulse_count == BatCntW'(1)) begin
                events.battery = 1'b1;
              end else if (bat_pulse_count == BatCntW'(2) && on_hook) begin
                events.polarity = 1'b1;
              end
            end
            bat_pulse_count_next = '0;
          end
        end
      end
      OP_RING: begin
        if (!ringing_active && ring_pulse_count == '0) begin
          ring_timer_kind_next = RK_ON;
          ring_timer_left_next = RingLeftW'(cfg.ring_on_ms);
        end else if (ringing_active) begin
          ring_pulse_count_next = '0;
          ring_timer_kind_next  = RK_END;
          ring_timer_left_next  = RingLeftW'(cfg.ring_on_ms) + RingLeftW'(cfg.ring_off_ms);
        end
        if (ring_pulse_count_next != '1) begin
          ring_pulse_count_next = ring_pulse_count_next + RingCntW'(1);
        end
      end
      OP_BATTERY: begin
        if (!cid_done) begin
          if (!cid_pending) begin
            cid_pending_next    = 1'b1;
            bat_timer_kind_next = BK_CID;
            bat_timer_left_next = cid_len[MsW] ? '1 : cid_len[MsW-1:0];
          end
        end else if (ring_pulse_count <= RingCntW'(2)) begin
          if (bat_pulse_count == '0) begin
            bat_timer_kind_next = BK_BAT;
            bat_timer_left_next = cfg.bat_window_ms;
          end
          if (bat_pulse_count != '1) begin
            bat_pulse_count_next = bat_pulse_count + BatCntW'(1);
          end
        end
      end
      default: begin
        events.polarity = !on_hook;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pulse_count <= '0;
      ringing_active   <= 1'b0;
      ring_timer_left  <= '0;
      ring_timer_kind  <= RK_IDLE;
      bat_pulse_count  <= '0;
      bat_timer_left   <= '0;
      bat_timer_kind   <= BK_IDLE;
      cid_done         <= 1'b0;
      cid_pending      <= 1'b0;
    end else if (fire) begin
      ring_pulse_count <= ring_pulse_count_next;
      ringing_active   <= ringing_active_next;
      ring_timer_left  <= ring_timer_left_next;
      ring_timer_kind  <= ring_timer_kind_next;
      bat_pulse_count  <= bat_pulse_count_next;
      bat_timer_left   <= bat_timer_left_next;
      bat_timer_kind   <= bat_timer_kind_next;
      cid_done         <= cid_done_next;
      cid_pending      <= cid_pending_next;
    end
  end

endmodule

// ===== design/phone_line_ring_and_battery_detector_core.sv =====
// ----------------------------------------------------------------------------
// phone_line_ring_and_battery_detector_core
// Detects ring start and end, battery pulses and polarity reversals from
// millisecond ticks and pin pulses.
//
//   Port group   Direction  Handshake           Contents
//   in           sink       in_valid/in_stall   op, on_hook
//   out          source     out_valid/out_stall four event flags
//   cfg          sink       cfg_write           cfg_index, cfg_data
//
// Each word gives exactly one result word in the result register. A word is
// taken every cycle while the output is not stalled; the input register, the
// state update and the result register form one pass with no loop.
// A stall on the output holds the result register and then the input register.
// Reset sets all windows idle and the config registers to their defaults.
// ----------------------------------------------------------------------------
module phone_line_ring_and_battery_detector_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic                          on_hook,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          ring_on_event,
  output logic                          ring_off_event,
  output logic                          battery_event,
  output logic                          polarity_event,
  input  logic                          cfg_write,
  input  logic [plrbd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [plrbd_pkg::MsW-1:0]     cfg_data
);
  import plrbd_pkg::*;

  cfg_t       cfg;
  events_t    events;
  logic       stage_valid;
  logic [1:0] stage_op;
  logic       stage_on_hook;
  logic       advance;
  logic       fire;

  assign advance  = !out_valid || !out_stall;
  assign fire     = stage_valid && advance;
  assign in_stall = stage_valid && !advance;

  plrbd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  plrbd_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .op      (stage_op),
    .on_hook (stage_on_hook),
    .cfg     (cfg),
    .events  (events)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage_op      <= op;
      stage_on_hook <= on_hook;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      ring_on_event  <= events.ring_on;
      ring_off_event <= events.ring_off;
      battery_event  <= events.battery;
      polarity_event <= events.polarity;
    end
  end

endmodule

// ===== tb/detector_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detector_event_checker
// Watches the input, output and register ports of the ring and battery
// detector. It keeps its own copy of the detector state and settings, works
// out the four event flags for every accepted input word, and checks each
// result word against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module detector_event_checker
  import plrbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         op,
  input  logic               on_hook,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               ring_on_event,
  input  logic               ring_off_event,
  input  logic               battery_event,
  input  logic               polarity_event,
  input  logic               cfg_write,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [MsW-1:0]     cfg_data,
  output int                 fail_count,
  output int                 pending
);

  logic [FreqW-1:0]     freq_hz;
  logic [MsW-1:0]       on_ms;
  logic [MsW-1:0]       off_ms;
  logic [MsW-1:0]       bat_ms;
  logic [MsW-1:0]       cid_ms;

  logic [RingCntW-1:0]  ring_count;
  logic                 ringing;
  logic [RingLeftW-1:0] ring_left;
  ring_kind_t           ring_kind;
  logic [BatCntW-1:0]   bat_count;
  logic [MsW-1:0]       bat_left;
  bat_kind_t            bat_kind;
  logic                 cid_done;
  logic                 cid_pending;

  events_t expected_events[$];
  int      errors = 0;
  string   flag_names[4] = '{"polarity_event", "battery_event", "ring_off_event",
                             "ring_on_event"};

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic clear_detector();
    freq_hz = FreqReset;
    on_ms = OnReset;
    off_ms = OffReset;
    bat_ms = BatReset;
    cid_ms = CidReset;
    ring_count = '0;
    ringing = 1'b0;
    ring_left = '0;
    ring_kind = RK_IDLE;
    bat_count = '0;
    bat_left = '0;
    bat_kind = BK_IDLE;
    cid_done = 1'b0;
    cid_pending = 1'b0;
  endtask

  function automatic logic [RingCntW-1:0] pulses_needed();
    logic [ProdW-1:0] prod;
    logic [ProdW-1:0] half;
    prod = ProdW'(freq_hz) * ProdW'(on_ms);
    half = (prod / ProdW'(1000)) >> 1;
    return (half < ProdW'(3)) ? RingCntW'(3) : half[RingCntW-1:0];
  endfunction

  task automatic step_detector(input op_t kind_in, input logic hook, output events_t ev);
    logic                 ring_fire;
    logic                 bat_fire;
    logic [RingCntW-1:0]  need;
    logic [MsW:0]         guard_len;
    ring_kind_t           old_ring;
    bat_kind_t            old_bat;
    ev = '0;
    need = pulses_needed();
    case (kind_in)
      OP_TICK: begin
        ring_fire = 1'b0;
        if (ring_kind != RK_IDLE) begin
          if (ring_left <= 1) begin
            ring_left = '0;
            ring_fire = 1'b1;
          end else begin
            ring_left = ring_left - 1'b1;
          end
        end
        if (ring_fire) begin
          old_ring = ring_kind;
          ring_kind = RK_IDLE;
          if (old_ring == RK_ON) begin
            if (ring_count >= need) begin
              ev.ring_on = 1'b1;
              ringing = 1'b1;
            end
            ring_count = '0;
          end else if (ring_count < need) begin
            ev.ring_off = 1'b1;
            ring_count = '0;
            ringing = 1'b0;
          end
        end
        bat_fire = 1'b0;
        if (bat_kind != BK_IDLE) begin
          if (bat_left <= 1) begin
            bat_left = '0;
            bat_fire = 1'b1;
          end else begin
            bat_left = bat_left - 1'b1;
          end
        end
        if (bat_fire) begin
          old_bat = bat_kind;
          bat_kind = BK_IDLE;
          if (old_bat == BK_CID) begin
            cid_done = 1'b1;
            cid_pending = 1'b0;
          end else begin
            if (!ringing) begin
              if (bat_count == 1) ev.battery = 1'b1;
              else if (bat_count == 2 && hook) ev.polarity = 1'b1;
            end
            bat_count = '0;
          end
        end
      end
      OP_RING: begin
        if (!ringing && ring_count == 0) begin
          ring_kind = RK_ON;
          ring_left = RingLeftW'(on_ms);
        end else if (ringing) begin
          ring_count = '0;
          ring_kind = RK_END;
          ring_left = RingLeftW'(on_ms) + RingLeftW'(off_ms);
        end
        if (ring_count != '1) ring_count = ring_count + 1'b1;
      end
      OP_BATTERY: begin
        if (!cid_done) begin
          if (!cid_pending) begin
            guard_len = (MsW+1)'(cid_ms) + CidExtra;
            cid_pending = 1'b1;
            bat_kind = BK_CID;
            bat_left = guard_len[MsW] ? '1 : guard_len[MsW-1:0];
          end
        end else if (ring_count <= 2) begin
          if (bat_count == 0) begin
            bat_kind = BK_BAT;
            bat_left = bat_ms;
          end
          if (bat_count != '1) bat_count = bat_count + 1'b1;
        end
      end
      default: begin
        if (!hook) ev.polarity = 1'b1;
      end
    endcase
  endtask

  always @(posedge clk) begin
    events_t got;
    events_t want;
    events_t fresh;
    if (rst) begin
      clear_detector();
      expected_events.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_RING_FREQ:  freq_hz = cfg_data[FreqW-1:0];
          REG_RING_ON:    on_ms = cfg_data;
          REG_RING_OFF:   off_ms = cfg_data;
          REG_BAT_WINDOW: bat_ms = cfg_data;
          REG_CID_WINDOW: cid_ms = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {ring_on_event, ring_off_event, battery_event, polarity_event};
        if (expected_events.size() == 0) begin
          $display("%0t ns: result word %b arrived with nothing expected", $time, got);
          errors++;
        end else begin
          want = expected_events.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (got[i] !== want[i]) begin
              $display("%0t ns: %s expected %b actual %b", $time, flag_names[i],
                       want[i], got[i]);
              errors++;
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        step_detector(op_t'(op), on_hook, fresh);
        expected_events.push_back(fresh);
      end
    end
    fail_count <= errors;
    pending <= expected_events.size();
  end

endmodule

// ===== tb/tb_phone_line_ring_and_battery_detector_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_phone_line_ring_and_battery_detector_core
// Drives ticks and pin pulses into the ring and battery detector under a
// series of register settings, from long windows down to zero-length ones.
// A directed opening covers the caller id guard, single and double battery
// pulses, ring start and ring end; random ring bursts, battery bursts and
// noise follow, with random gaps on both sides of the block.
// ----------------------------------------------------------------------------
module tb_phone_line_ring_and_battery_detector_core;
  import plrbd_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpare = 3'd7;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         op;
  logic               on_hook;
  logic               out_valid;
  logic               out_stall;
  logic               ring_on_event;
  logic               ring_off_event;
  logic               battery_event;
  logic               polarity_event;
  logic               cfg_write;
  logic [CfgIdxW-1:0] cfg_index;
  logic [MsW-1:0]     cfg_data;
  int                 fail_count;
  int                 pending;

  logic calm;
  logic line_hook;
  int   words_sent;
  int   on_len;
  int   off_len;
  int   bat_len;
  int   burst_cap;

  phone_line_ring_and_battery_detector_core uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .on_hook        (on_hook),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ring_on_event  (ring_on_event),
    .ring_off_event (ring_off_event),
    .battery_event  (battery_event),
    .polarity_event (polarity_event),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  detector_event_checker event_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .on_hook        (on_hook),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .ring_on_event  (ring_on_event),
    .ring_off_event (ring_off_event),
    .battery_event  (battery_event),
    .polarity_event (polarity_event),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 23);
    end
  end

  initial begin
    #4000000;
    $display("tb_phone_line_ring_and_battery_detector_core: errors");
    $finish;
  end

  task automatic push_word(input op_t kind_in, input logic hook);
    while (!calm && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= kind_in;
    on_hook <= hook;
    do @(posedge clk); while (in_stall);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_ticks(input int count, input logic hook);
    repeat (count) push_word(OP_TICK, hook);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [MsW-1:0] value);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_config(input int freq, input int on, input int off, input int bat,
                             input int cid, input int cap);
    write_reg(REG_RING_FREQ, MsW'(freq));
    write_reg(REG_RING_ON, MsW'(on));
    write_reg(REG_RING_OFF, MsW'(off));
    write_reg(REG_BAT_WINDOW, MsW'(bat));
    write_reg(REG_CID_WINDOW, MsW'(cid));
    on_len = on;
    off_len = off;
    bat_len = bat;
    burst_cap = cap;
  endtask

  task automatic run_random(input int quota);
    int start;
    int count;
    start = words_sent;
    while (words_sent - start < quota) begin
      if ($urandom_range(0, 7) == 0) line_hook = ~line_hook;
      case ($urandom_range(0, 10))
        0, 1, 2, 3: begin
          count = $urandom_range(0, burst_cap);
          repeat (count) begin
            push_word(OP_RING, line_hook);
            send_ticks($urandom_range(0, 2), line_hook);
          end
          send_ticks($urandom_range(0, on_len + off_len + 2), line_hook);
        end
        4, 5, 6: begin
          count = $urandom_range(1, 3);
          repeat (count) begin
            push_word(OP_BATTERY, line_hook);
            send_ticks($urandom_range(0, 1), line_hook);
          end
          send_ticks(bat_len + $urandom_range(0, 2), line_hook);
        end
        7: push_word(OP_POLARITY, 1'($urandom_range(0, 1)));
        8: begin
          repeat ($urandom_range(1, 5))
            push_word(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
        9: drain_results();
        default: send_ticks($urandom_range(0, on_len + off_len + 2), line_hook);
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_TICK;
    on_hook = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_RING_FREQ;
    cfg_data = '0;
    calm = 1'b0;
    line_hook = 1'b1;
    words_sent = 0;
    on_len = 1000;
    off_len = 4000;
    bat_len = 100;
    burst_cap = 14;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The second battery pulse falls inside the guard, and four pulses are
    // too few for the on-window. Then single and double battery pulses on and
    // off hook, a ring start and its end.
    load_config(255, 40, 30, 10, 20, 14);
    push_word(OP_POLARITY, 1'b0);
    push_word(OP_POLARITY, 1'b1);
    push_word(OP_TICK, 1'b1);
    push_word(OP_BATTERY, 1'b1);
    push_word(OP_BATTERY, 1'b1);
    repeat (4) push_word(OP_RING, 1'b1);
    send_ticks(45, 1'b1);

    push_word(OP_BATTERY, 1'b1);
    send_ticks(11, 1'b1);
    repeat (2) push_word(OP_BATTERY, 1'b1);
    send_ticks(11, 1'b1);
    repeat (2) push_word(OP_BATTERY, 1'b0);
    send_ticks(11, 1'b0);
    repeat (6) push_word(OP_RING, 1'b1);
    push_word(OP_BATTERY, 1'b1);
    send_ticks(41, 1'b1);
    push_word(OP_RING, 1'b1);
    send_ticks(75, 1'b1);

    // The battery window closes on the same tick that ringing starts, then
    // the end window runs out with no gaps on either side.
    load_config(0, 40, 40, 40, 0, 5);
    repeat (2) push_word(OP_BATTERY, 1'b1);
    repeat (4) push_word(OP_RING, 1'b1);
    send_ticks(40, 1'b1);
    push_word(OP_RING, 1'b1);
    calm = 1'b1;
    send_ticks(80, 1'b1);
    calm = 1'b0;

    load_config(16383, 20, 30, 6, 0, 6);
    repeat (257) push_word(OP_BATTERY, 1'b1);
    send_ticks(7, 1'b1);
    run_random(220);

    load_config(200, 50, 10, 1, 10000, 8);
    run_random(220);

    load_config(0, 0, 0, 0, 0, 5);
    write_reg(RegSpare, 14'h3FFF);
    run_random(220);

    load_config(255, 63, 25, 12, 5, 11);
    run_random(220);

    drain_results();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_phone_line_ring_and_battery_detector_core: clean");
    end else begin
      $display("tb_phone_line_ring_and_battery_detector_core: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/plrbd_pkg.sv
design/plrbd_cfg.sv
design/plrbd_engine.sv
design/phone_line_ring_and_battery_detector_core.sv
tb/detector_event_checker.sv
tb/tb_phone_line_ring_and_battery_detector_core.sv
